/* hw/rtl/ehw_pkg.sv */
// ----------------------------------------------------------------------------
// ehw_pkg
// Types, codes and helpers shared by the IPv6 extension header walker.
// ----------------------------------------------------------------------------
package ehw_pkg;

  localparam logic [7:0] NH_HOPOPTS  = 8'd0;
  localparam logic [7:0] NH_ROUTING  = 8'd43;
  localparam logic [7:0] NH_FRAGMENT = 8'd44;
  localparam logic [7:0] NH_ESP      = 8'd50;
  localparam logic [7:0] NH_AH       = 8'd51;
  localparam logic [7:0] NH_DSTOPTS  = 8'd60;

  typedef enum logic [1:0] {
    ST_UPPER     = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_BADLEN    = 2'd2,
    ST_FRAGMENT  = 2'd3
  } walk_status_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       start_of_payload;
    logic [7:0] initial_next_header;
    logic       end_of_payload;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cur_nh;
    logic [7:0]  pend_nh;
    logic [11:0] pos;
    logic [11:0] hdr_len;
    logic [15:0] hdr_start;
    logic [15:0] byte_off;
    logic        done;
  } walk_state_t;

  function automatic logic is_extension(input logic [7:0] nh);
    return (nh == NH_HOPOPTS) || (nh == NH_ROUTING) || (nh == NH_DSTOPTS) ||
           (nh == NH_FRAGMENT) || (nh == NH_AH) || (nh == NH_ESP);
  endfunction

  // AH: (len+2)*4, others: (len+1)*8; both fit in 12 bits
  function automatic logic [11:0] hdr_bytes(input logic [7:0] nh, input logic [7:0] len);
    logic [8:0] ah_sum;
    logic [8:0] ext_sum;
    ah_sum  = {1'b0, len} + 9'd2;
    ext_sum = {1'b0, len} + 9'd1;
    if (nh == NH_AH) begin
      return {1'b0, ah_sum, 2'b00};
    end
    return {ext_sum, 3'b000};
  endfunction

endpackage

/* hw/rtl/ehw_if.sv */
// ----------------------------------------------------------------------------
// ehw interfaces
// Valid/ready channels for payload bytes and walk results.
// ----------------------------------------------------------------------------
interface ehw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       start_of_payload;
  logic [7:0] initial_next_header;
  logic       end_of_payload;

  modport source (output valid, payload_byte, start_of_payload, initial_next_header,
                  end_of_payload, input ready);
  modport sink   (input valid, payload_byte, start_of_payload, initial_next_header,
                  end_of_payload, output ready);
endinterface

interface ehw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  final_protocol;
  logic [1:0]  walk_status;
  logic [15:0] upper_offset;

  modport source (output valid, final_protocol, walk_status, upper_offset, input ready);
  modport sink   (input valid, final_protocol, walk_status, upper_offset, output ready);
endinterface

/* hw/rtl/ehw_in_reg.sv */
// ----------------------------------------------------------------------------
// ehw_in_reg
// Input register: holds one payload byte transaction for the walk stage.
// ----------------------------------------------------------------------------
module ehw_in_reg
  import ehw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  ehw_in_if.sink   payload,
  output in_item_t item,
  output logic     item_valid,
  input  logic     item_take
);

  logic accept;

  assign payload.ready = !item_valid || item_take;
  assign accept        = payload.valid && payload.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.payload_byte        <= payload.payload_byte;
      item.start_of_payload    <= payload.start_of_payload;
      item.initial_next_header <= payload.initial_next_header;
      item.end_of_payload      <= payload.end_of_payload;
    end
  end

endmodule

/* hw/rtl/ehw_walk.sv */
// ----------------------------------------------------------------------------
// ehw_walk
// Per-byte chain walk state update and the result register.
// ----------------------------------------------------------------------------
module ehw_walk
  import ehw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  in_item_t item,
  input  logic     item_valid,
  output logic     item_take,
  ehw_out_if.source result
);

  walk_state_t  st;
  walk_state_t  st_next;
  logic         emit;
  logic [7:0]   res_proto;
  walk_status_t res_status;
  logic [15:0]  res_off;
  logic [15:0]  here;
  logic [11:0]  len_now;

  assign item_take = item_valid && (!result.valid || result.ready);

  always_comb begin
    st_next    = st;
    emit       = 1'b0;
    res_proto  = st.cur_nh;
    res_status = ST_UPPER;
    res_off    = st.hdr_start;
    here       = st.byte_off;
    len_now    = st.hdr_len;
    if (item_take) begin
      if (item.start_of_payload) begin
        st_next.cur_nh    = item.initial_next_header;
        st_next.pend_nh   = '0;
        st_next.pos       = '0;
        st_next.hdr_len   = '0;
        st_next.hdr_start = '0;
        st_next.byte_off  = '0;
        st_next.done      = 1'b0;
      end
      if (item.start_of_payload && !is_extension(item.initial_next_header)) begin
        emit         = 1'b1;
        res_proto    = item.initial_next_header;
        res_status   = ST_UPPER;
        res_off      = '0;
        st_next.done = 1'b1;
      end else if (!st_next.done) begin
        here             = st_next.byte_off;
        st_next.byte_off = here + 16'd1;
        if (st_next.pos == '0) begin
          st_next.pend_nh = item.payload_byte;
          if (item.end_of_payload) begin
            emit         = 1'b1;
            res_proto    = st_next.cur_nh;
            res_status   = ST_TRUNCATED;
            res_off      = st_next.hdr_start;
            st_next.done = 1'b1;
          end else begin
            st_next.pos = 12'd1;
          end
        end else begin
          len_now = (st_next.pos == 12'd1) ? hdr_bytes(st_next.cur_nh, item.payload_byte)
                                           : st_next.hdr_len;
          st_next.hdr_len = len_now;
          if (({1'b0, st_next.pos} + 13'd1) == {1'b0, len_now}) begin
            if (st_next.cur_nh == NH_FRAGMENT) begin
              emit         = 1'b1;
              res_proto    = st_next.cur_nh;
              res_status   = ST_FRAGMENT;
              res_off      = st_next.hdr_start;
              st_next.done = 1'b1;
            end else begin
              st_next.cur_nh    = st_next.pend_nh;
              st_next.hdr_start = here + 16'd1;
              st_next.pos       = '0;
              st_next.hdr_len   = '0;
              res_proto         = st_next.pend_nh;
              res_off           = here + 16'd1;
              if (!is_extension(st_next.pend_nh)) begin
                emit         = 1'b1;
                res_status   = ST_UPPER;
                st_next.done = 1'b1;
              end else if (item.end_of_payload) begin
                emit         = 1'b1;
                res_status   = ST_TRUNCATED;
                st_next.done = 1'b1;
              end
            end
          end else if (item.end_of_payload) begin
            emit         = 1'b1;
            res_proto    = st_next.cur_nh;
            res_status   = ST_BADLEN;
            res_off      = st_next.hdr_start;
            st_next.done = 1'b1;
          end else begin
            st_next.pos = st_next.pos + 12'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{cur_nh: '0, pend_nh: '0, pos: '0, hdr_len: '0, hdr_start: '0,
              byte_off: '0, done: 1'b1};
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (item_take && emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      result.final_protocol <= res_proto;
      result.walk_status    <= res_status;
      result.upper_offset   <= res_off;
    end
  end

endmodule

/* hw/rtl/ipv6_ext_header_walker_unit.sv */
// ----------------------------------------------------------------------------
// ipv6_ext_header_walker_unit
// Walks the IPv6 extension header chain over the payload byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   payload: one payload byte per transaction; start_of_payload marks the
//     first byte and carries the fixed header's next-header value,
//     end_of_payload marks the last byte.
//   result: one transaction per packet with the final protocol, walk
//     status and the byte offset of the stopping header.
//   Throughput is one byte per cycle while the result receiver does not
//   stall. A result is registered: the byte that ends the walk passes the
//   input register, then the result register. Bytes after the result and
//   before the next start are dropped; a new start abandons an unfinished
//   walk without a result. Reset leaves the walker idle, waiting for a start
//   byte, with no result pending. While the result receiver stalls, one more
//   byte is held in the input register; further bytes wait on payload.ready.
// ----------------------------------------------------------------------------
module ipv6_ext_header_walker_unit
  import ehw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ehw_in_if.sink     payload,
  ehw_out_if.source  result
);

  in_item_t item;
  logic     item_valid;
  logic     item_take;

  ehw_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .payload    (payload),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  ehw_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .result     (result)
  );

endmodule
